>>> hw/rtl/ght_pkg.sv
// Shared constants, types and helper function of the generational handle table.
`default_nettype none

package ght_pkg;

    // Slot storage geometry and handle layout.
    localparam int SLOTS      = 1024;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int POS_W      = 11;
    localparam int INDEX_BITS = 24;
    localparam int GEN_BITS   = 8;
    localparam int HANDLE_W   = 32;
    localparam int CMD_W      = 2;
    localparam int CAP_RESET  = 1024;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_RESOLVE = 2'd2,
        CMD_SCAN    = 2'd3
    } cmd_t;

    // One slot entry as it sits in the slot memory.
    typedef struct packed {
        logic                live;
        logic [GEN_BITS-1:0] gen;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Write request from the engine to the slot memory.
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        entry_t            data;
    } ram_wr_t;

    // One result transaction.
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic                ok;
        logic [SLOT_W-1:0]   slot_index;
        logic [POS_W-1:0]    next_cursor;
    } result_t;

    // Builds a handle: slot plus one in the index field, generation above it.
    function automatic logic [HANDLE_W-1:0] make_handle(
        input logic [SLOT_W-1:0]   slot,
        input logic [GEN_BITS-1:0] gen
    );
        logic [POS_W-1:0] idx;
        idx = POS_W'(slot) + POS_W'(1);
        return HANDLE_W'(idx) | (HANDLE_W'(gen) << INDEX_BITS);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ght_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module ght_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 9
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/ght_engine.sv
// Command sequencer: clearing pass, slot read-modify-write, live scan and result register.
`default_nettype none

module ght_engine (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [ght_pkg::POS_W-1:0]      capacity,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [ght_pkg::CMD_W-1:0]      cmd,
    input  wire logic [ght_pkg::HANDLE_W-1:0]   handle_in,
    input  wire logic [ght_pkg::SLOT_W-1:0]     alloc_slot,
    input  wire logic                           alloc_ok,
    input  wire logic [ght_pkg::POS_W-1:0]      cursor,
    input  wire logic [ght_pkg::POS_W-1:0]      scan_limit,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output ght_pkg::result_t                    result,
    output ght_pkg::ram_wr_t                    ram_wr,
    output logic [ght_pkg::SLOT_W-1:0]          ram_raddr,
    input  wire logic [ght_pkg::ENTRY_W-1:0]    ram_rdata
);

    import ght_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_LOOK  = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_HOLD  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [SLOT_W-1:0]    clr_reg, clr_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 chk_valid_reg, chk_valid_next;
    result_t              out_reg, out_next;
    result_t              pend_reg, pend_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [GEN_BITS-1:0]  hgen_reg, hgen_next;
    logic                 hvalid_reg, hvalid_next;
    logic [POS_W-1:0]     end_reg, end_next;
    logic [POS_W-1:0]     limit_reg, limit_next;
    logic [POS_W-1:0]     iss_reg, iss_next;
    logic [SLOT_W-1:0]    chk_reg, chk_next;

    logic [INDEX_BITS-1:0] idx_c;
    logic                  idx_ok_c;
    logic                  alloc_good_c;
    logic [SLOT_W-1:0]     req_slot_c;
    entry_t                entry_c;
    result_t               res_c;
    logic                  done_c;
    logic                  out_free_c;

    // Decode of the incoming item, used at the accepting edge.
    assign idx_c        = handle_in[INDEX_BITS-1:0];
    assign idx_ok_c     = (idx_c != '0) && (idx_c <= INDEX_BITS'(capacity));
    assign alloc_good_c = alloc_ok && (POS_W'(alloc_slot) < capacity);
    assign req_slot_c   = (cmd_t'(cmd) == CMD_ALLOC) ? alloc_slot
                                                      : SLOT_W'(idx_c - INDEX_BITS'(1));
    assign entry_c      = entry_t'(ram_rdata);
    assign out_free_c   = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        chk_valid_next = chk_valid_reg;
        out_next       = out_reg;
        pend_next      = pend_reg;
        cmd_next       = cmd_reg;
        slot_next      = slot_reg;
        hgen_next      = hgen_reg;
        hvalid_next    = hvalid_reg;
        end_next       = end_reg;
        limit_next     = limit_reg;
        iss_next       = iss_reg;
        chk_next       = chk_reg;
        ram_wr         = '0;
        ram_raddr      = iss_reg[SLOT_W-1:0];
        res_c          = '0;
        done_c         = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_wr.we   = 1'b1;
                ram_wr.addr = clr_reg;
                clr_next    = clr_reg + SLOT_W'(1);
                if (clr_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ram_raddr = req_slot_c;
                if (in_valid)
                begin
                    cmd_next       = cmd_t'(cmd);
                    slot_next      = req_slot_c;
                    hgen_next      = handle_in[INDEX_BITS +: GEN_BITS];
                    hvalid_next    = (cmd_t'(cmd) == CMD_ALLOC) ? alloc_good_c : idx_ok_c;
                    end_next       = (scan_limit < POS_W'(SLOTS)) ? scan_limit
                                                                  : POS_W'(SLOTS);
                    limit_next     = scan_limit;
                    iss_next       = cursor;
                    chk_valid_next = 1'b0;
                    state_next     = (cmd_t'(cmd) == CMD_SCAN) ? ST_SCAN : ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                done_c = 1'b1;
                unique case (cmd_reg)
                    CMD_ALLOC:
                    begin
                        if (hvalid_reg)
                        begin
                            ram_wr.we         = 1'b1;
                            ram_wr.addr       = slot_reg;
                            ram_wr.data.live  = 1'b1;
                            ram_wr.data.gen   = entry_c.gen;
                            res_c.handle      = make_handle(slot_reg, entry_c.gen);
                            res_c.ok          = 1'b1;
                            res_c.slot_index  = slot_reg;
                        end
                    end
                    CMD_FREE:
                    begin
                        if (hvalid_reg && entry_c.live && (entry_c.gen == hgen_reg))
                        begin
                            ram_wr.we         = 1'b1;
                            ram_wr.addr       = slot_reg;
                            ram_wr.data.live  = 1'b0;
                            ram_wr.data.gen   = entry_c.gen + GEN_BITS'(1);
                            res_c.ok          = 1'b1;
                            res_c.slot_index  = slot_reg;
                        end
                    end
                    CMD_RESOLVE:
                    begin
                        if (hvalid_reg && entry_c.live && (entry_c.gen == hgen_reg))
                        begin
                            res_c.ok         = 1'b1;
                            res_c.slot_index = slot_reg;
                        end
                    end
                    CMD_SCAN:
                    begin
                        // Scans never pass through this state; the result stays null.
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (chk_valid_reg && entry_c.live)
                begin
                    done_c            = 1'b1;
                    res_c.handle      = make_handle(chk_reg, entry_c.gen);
                    res_c.ok          = 1'b1;
                    res_c.slot_index  = chk_reg;
                    res_c.next_cursor = POS_W'(chk_reg) + POS_W'(1);
                end
                else if (iss_reg >= end_reg)
                begin
                    done_c            = 1'b1;
                    res_c.next_cursor = limit_reg;
                end
                else
                begin
                    ram_raddr      = iss_reg[SLOT_W-1:0];
                    chk_next       = iss_reg[SLOT_W-1:0];
                    chk_valid_next = 1'b1;
                    iss_next       = iss_reg + POS_W'(1);
                end
            end
            ST_HOLD:
            begin
                done_c = 1'b1;
                res_c  = pend_reg;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        if (done_c)
        begin
            if (out_free_c)
            begin
                out_next       = res_c;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            else
            begin
                pend_next  = res_c;
                state_next = ST_HOLD;
            end
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg    <= out_next;
        pend_reg   <= pend_next;
        cmd_reg    <= cmd_next;
        slot_reg   <= slot_next;
        hgen_reg   <= hgen_next;
        hvalid_reg <= hvalid_next;
        end_reg    <= end_next;
        limit_reg  <= limit_next;
        iss_reg    <= iss_next;
        chk_reg    <= chk_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign result    = out_reg;

endmodule

`default_nettype wire

>>> hw/rtl/generational_handle_table.sv
// Top level of the generational handle table: capacity register, engine and slot memory.
// Alloc, free and resolve: the slot entry is read on acceptance and the result is registered
// from the look state, or held while the result channel stalls; the next command waits for it.
// Scan: the walk reads one slot memory entry per cycle from the cursor up to the scan limit,
// stopping at the first live slot. Reset: capacity returns to 1024, and a clearing pass
// zeroes the slot memory while input transactions stall; configuration writes are taken throughout.
`default_nettype none

module generational_handle_table (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // Configuration write channel: slot_capacity.
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [ght_pkg::POS_W-1:0]    cfg_data,
    // Command channel.
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [ght_pkg::CMD_W-1:0]    cmd,
    input  wire logic [ght_pkg::HANDLE_W-1:0] handle_in,
    input  wire logic [ght_pkg::SLOT_W-1:0]   alloc_slot,
    input  wire logic                         alloc_ok,
    input  wire logic [ght_pkg::POS_W-1:0]    cursor,
    input  wire logic [ght_pkg::POS_W-1:0]    scan_limit,
    // Result channel.
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [ght_pkg::HANDLE_W-1:0]      handle_out,
    output logic                              ok,
    output logic [ght_pkg::SLOT_W-1:0]        slot_index,
    output logic [ght_pkg::POS_W-1:0]         next_cursor
);

    import ght_pkg::*;

    logic [POS_W-1:0]  cap_reg;
    logic [POS_W-1:0]  cap_eff;
    result_t           result;
    ram_wr_t           ram_wr;
    logic [SLOT_W-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    // The register is always ready; an accepted write is registered straight into cap_reg.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= POS_W'(CAP_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= cfg_data;
        end
    end

    // The usable capacity never exceeds the physical slot count.
    assign cap_eff = (cap_reg < POS_W'(SLOTS)) ? cap_reg : POS_W'(SLOTS);

    ght_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .capacity   (cap_eff),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .handle_in  (handle_in),
        .alloc_slot (alloc_slot),
        .alloc_ok   (alloc_ok),
        .cursor     (cursor),
        .scan_limit (scan_limit),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result     (result),
        .ram_wr     (ram_wr),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    // Each entry holds the live bit and the generation of one slot.
    ght_ram #(
        .DEPTH (SLOTS),
        .WIDTH (ENTRY_W)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_wr.we),
        .waddr (ram_wr.addr),
        .wdata (ram_wr.data),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign handle_out  = result.handle;
    assign ok          = result.ok;
    assign slot_index  = result.slot_index;
    assign next_cursor = result.next_cursor;

endmodule

`default_nettype wire
